FILE: rtl/core/light_bar_pair_matcher_macros.svh
// Assertion macros used by the light bar pair matcher checker.
`ifndef LIGHT_BAR_PAIR_MATCHER_MACROS_SVH
`define LIGHT_BAR_PAIR_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define LBPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbpm assertion failed");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define LBPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbpm assertion failed");

`endif

FILE: rtl/core/lbpm_pkg.sv
// Shared constants of the light bar pair matcher: request codes, register indexes and reset values.
package lbpm_pkg;

    // request operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // configuration register indexes
    localparam logic [7:0] REG_ASPECT_MIN = 8'd0;
    localparam logic [7:0] REG_ASPECT_MAX = 8'd1;
    localparam logic [7:0] REG_GAP_MIN    = 8'd2;
    localparam logic [7:0] REG_GAP_MAX    = 8'd3;

    // register reset values, tenths
    localparam logic [7:0] ASPECT_MIN_RST = 8'd10;
    localparam logic [7:0] ASPECT_MAX_RST = 8'd35;
    localparam logic [7:0] GAP_MIN_RST    = 8'd12;
    localparam logic [7:0] GAP_MAX_RST    = 8'd50;

    localparam int unsigned RATIO_BITS = 8;

endpackage

FILE: rtl/core/light_bar_pair_matcher.sv
// Light bar pair matcher: box table, pair scan sequencer and shared ratio check unit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  request   | i_start, o_busy        | i_operation, i_center_x, i_box_left, i_box_top,
//            |                        | i_box_width, i_box_height
//  result    | o_strobe (one cycle)   | o_pair_valid, o_pair_left, o_pair_top,
//            |                        | o_pair_span, o_pair_height, o_table_full, o_last
//  config    | i_cfg_we               | i_cfg_addr, i_cfg_data
//
// Load, clear and no-op requests keep o_busy low; each result is registered and shows in the next cycle.
// A run holds o_busy high: it accepts the request, then per outer box reads it and runs up
// to two shape tests, per inner box reads it and runs up to six ratio tests, each in a product
// phase and a compare phase, plus a match step per match, then gives the final result.
// i_rst_n is synchronous, active low: count to zero (entries kept), register reset values.
// The receiver cannot stall.
module light_bar_pair_matcher
    import lbpm_pkg::*;
#(
    parameter int unsigned MAX_BOXES  = 512,
    parameter int unsigned MAX_PAIRS  = 12,
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_operation,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_box_left,
    input  logic [COORD_BITS-1:0] i_box_top,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    output logic                  o_strobe,
    output logic                  o_pair_valid,
    output logic [COORD_BITS-1:0] o_pair_left,
    output logic [COORD_BITS-1:0] o_pair_top,
    output logic [COORD_BITS-1:0] o_pair_span,
    output logic [COORD_BITS-1:0] o_pair_height,
    output logic                  o_table_full,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_addr,
    input  logic [7:0]            i_cfg_data
);

    localparam int unsigned AW    = $clog2(MAX_BOXES);      // table index
    localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);  // box count
    localparam int unsigned NW    = $clog2(MAX_PAIRS + 1);  // match count
    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned PW    = CB + RATIO_BITS;        // product width

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD_A  = 4'd1;  // address outer box
    localparam logic [3:0] S_LAT_A = 4'd2;  // capture outer box
    localparam logic [3:0] S_CHK_A = 4'd3;  // outer shape tests
    localparam logic [3:0] S_RD_B  = 4'd4;  // address inner box
    localparam logic [3:0] S_LAT_B = 4'd5;  // capture inner box, distance
    localparam logic [3:0] S_CHK_B = 4'd6;  // inner shape and gap tests
    localparam logic [3:0] S_MATCH = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;  // final result of a run

    typedef struct packed {
        logic [CB-1:0] cx;
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
    } t_box;

    // table memory, one write and one registered read port
    t_box             mem [MAX_BOXES];
    t_box             r_rd_data;
    logic             mem_we;
    logic [AW-1:0]    mem_raddr;

    // control
    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_p, n_p;
    logic [CNT_W-1:0] r_q, n_q;
    logic [NW-1:0]    r_np, n_np;
    logic [2:0]       r_chk, n_chk;
    logic             r_ph, n_ph;
    logic             r_pend, n_pend;
    logic             r_out_stb, n_out_stb;
    logic [7:0]       r_amin, r_amax, r_gmin, r_gmax;

    // payload
    t_box             r_a, n_a;
    t_box             r_b, n_b;
    logic [CB-1:0]    r_d, n_d;
    logic [PW-1:0]    r_prod, n_prod;
    logic [PW-1:0]    r_lhs, n_lhs;
    logic [CB-1:0]    r_pd_left, n_pd_left, r_pd_top, n_pd_top;
    logic [CB-1:0]    r_pd_span, n_pd_span, r_pd_hgt, n_pd_hgt;
    logic             r_out_valid, n_out_valid, r_out_full, n_out_full;
    logic             r_out_last, n_out_last;
    logic [CB-1:0]    r_out_left, n_out_left, r_out_top, n_out_top;
    logic [CB-1:0]    r_out_span, n_out_span, r_out_hgt, n_out_hgt;

    // shared check unit operands
    logic [7:0]       k_sel;
    logic [CB-1:0]    w_sel, x_sel;
    logic             ge_sel, last_chk, chk_pass;

    logic [CNT_W-1:0] p_inc, q_inc;
    logic             room;

    assign p_inc = r_p + CNT_W'(1);
    assign q_inc = r_q + CNT_W'(1);
    assign room  = (r_cnt < CNT_W'(MAX_BOXES));
    assign mem_raddr = (r_state == S_RD_A) ? r_p[AW-1:0] : r_q[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[AW-1:0]] <= t_box'({i_center_x, i_box_left, i_box_top,
                                          i_box_width, i_box_height});
        end
        r_rd_data <= mem[mem_raddr];
    end

    // test list: outer box two shape tests; inner box two shape tests, then the
    // gap against the outer width and against the inner width
    always_comb begin
        k_sel    = r_amin;
        w_sel    = r_a.w;
        x_sel    = r_a.h;
        ge_sel   = 1'b1;
        last_chk = 1'b0;
        if (r_state == S_CHK_A) begin
            case (r_chk)
                3'd0:    begin k_sel = r_amin; ge_sel = 1'b1; end
                3'd1:    begin k_sel = r_amax; ge_sel = 1'b0; last_chk = 1'b1; end
                default: begin k_sel = r_amax; ge_sel = 1'b0; last_chk = 1'b1; end
            endcase
        end else begin
            case (r_chk)
                3'd0: begin k_sel = r_amin; w_sel = r_b.w; x_sel = r_b.h; ge_sel = 1'b1; end
                3'd1: begin k_sel = r_amax; w_sel = r_b.w; x_sel = r_b.h; ge_sel = 1'b0; end
                3'd2: begin k_sel = r_gmin; w_sel = r_a.w; x_sel = r_d;   ge_sel = 1'b1; end
                3'd3: begin k_sel = r_gmax; w_sel = r_a.w; x_sel = r_d;   ge_sel = 1'b0; end
                3'd4: begin k_sel = r_gmin; w_sel = r_b.w; x_sel = r_d;   ge_sel = 1'b1; end
                default: begin
                    k_sel = r_gmax; w_sel = r_b.w; x_sel = r_d; ge_sel = 1'b0;
                    last_chk = 1'b1;
                end
            endcase
        end
    end

    // phase 0 registers k*w and 10*x, phase 1 compares
    assign n_prod   = PW'(k_sel) * PW'(w_sel);
    assign n_lhs    = PW'({x_sel, 3'b000}) + PW'({x_sel, 1'b0});
    assign chk_pass = ge_sel ? (r_lhs >= r_prod) : (r_lhs <= r_prod);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_p         = r_p;
        n_q         = r_q;
        n_np        = r_np;
        n_chk       = r_chk;
        n_ph        = r_ph;
        n_pend      = r_pend;
        n_a         = r_a;
        n_b         = r_b;
        n_d         = r_d;
        n_pd_left   = r_pd_left;
        n_pd_top    = r_pd_top;
        n_pd_span   = r_pd_span;
        n_pd_hgt    = r_pd_hgt;
        n_out_stb   = 1'b0;
        n_out_valid = r_out_valid;
        n_out_left  = r_out_left;
        n_out_top   = r_out_top;
        n_out_span  = r_out_span;
        n_out_hgt   = r_out_hgt;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_out_valid = 1'b0;
                    n_out_left  = '0;
                    n_out_top   = '0;
                    n_out_span  = '0;
                    n_out_hgt   = '0;
                    n_out_full  = 1'b0;
                    n_out_last  = 1'b1;
                    case (i_operation)
                        OP_LOAD: begin
                            n_out_stb  = 1'b1;
                            n_out_full = !room;
                            if (room) begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_RUN: begin
                            n_np   = '0;
                            n_pend = 1'b0;
                            if (r_cnt < CNT_W'(2)) begin
                                n_state = S_FIN;
                            end else begin
                                n_p     = CNT_W'(1);
                                n_state = S_RD_A;
                            end
                        end
                        OP_CLEAR: begin
                            n_out_stb = 1'b1;
                            n_cnt     = '0;
                        end
                        default: begin
                            n_out_stb = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_A: begin
                n_state = S_LAT_A;
            end
            S_LAT_A: begin
                n_a   = r_rd_data;
                n_chk = '0;
                n_ph  = 1'b0;
                if (r_rd_data.w == '0) begin
                    // zero width never matches: next outer box
                    n_p     = p_inc;
                    n_state = (p_inc >= r_cnt) ? S_FIN : S_RD_A;
                end else begin
                    n_state = S_CHK_A;
                end
            end
            S_CHK_A: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (!chk_pass) begin
                        n_p     = p_inc;
                        n_state = (p_inc >= r_cnt) ? S_FIN : S_RD_A;
                    end else if (last_chk) begin
                        n_q     = '0;
                        n_state = S_RD_B;
                    end else begin
                        n_chk = r_chk + 3'd1;
                    end
                end
            end
            S_RD_B: begin
                n_state = S_LAT_B;
            end
            S_LAT_B: begin
                n_b   = r_rd_data;
                n_d   = (r_a.cx >= r_rd_data.cx) ? (r_a.cx - r_rd_data.cx)
                                                 : (r_rd_data.cx - r_a.cx);
                n_chk = '0;
                n_ph  = 1'b0;
                if (r_rd_data.w == '0) begin
                    if (q_inc >= r_p) begin
                        n_p     = p_inc;
                        n_state = (p_inc >= r_cnt) ? S_FIN : S_RD_A;
                    end else begin
                        n_q     = q_inc;
                        n_state = S_RD_B;
                    end
                end else begin
                    n_state = S_CHK_B;
                end
            end
            S_CHK_B: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (!chk_pass) begin
                        if (q_inc >= r_p) begin
                            n_p     = p_inc;
                            n_state = (p_inc >= r_cnt) ? S_FIN : S_RD_A;
                        end else begin
                            n_q     = q_inc;
                            n_state = S_RD_B;
                        end
                    end else if (last_chk) begin
                        n_state = S_MATCH;
                    end else begin
                        n_chk = r_chk + 3'd1;
                    end
                end
            end
            S_MATCH: begin
                // the held match goes out now; last is known only for the newest
                if (r_pend) begin
                    n_out_stb   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_left  = r_pd_left;
                    n_out_top   = r_pd_top;
                    n_out_span  = r_pd_span;
                    n_out_hgt   = r_pd_hgt;
                    n_out_full  = 1'b0;
                    n_out_last  = 1'b0;
                end
                n_pend    = 1'b1;
                n_pd_left = (r_a.left < r_b.left) ? r_a.left : r_b.left;
                n_pd_top  = (r_a.top < r_b.top) ? r_a.top : r_b.top;
                n_pd_span = r_d;
                n_pd_hgt  = (r_a.h > r_b.h) ? r_a.h : r_b.h;
                n_np      = r_np + NW'(1);
                if (n_np == NW'(MAX_PAIRS)) begin
                    n_state = S_FIN;
                end else if (q_inc >= r_p) begin
                    n_p     = p_inc;
                    n_state = (p_inc >= r_cnt) ? S_FIN : S_RD_A;
                end else begin
                    n_q     = q_inc;
                    n_state = S_RD_B;
                end
            end
            S_FIN: begin
                n_out_stb   = 1'b1;
                n_out_valid = r_pend;
                n_out_left  = r_pend ? r_pd_left : '0;
                n_out_top   = r_pend ? r_pd_top : '0;
                n_out_span  = r_pend ? r_pd_span : '0;
                n_out_hgt   = r_pend ? r_pd_hgt : '0;
                n_out_full  = 1'b0;
                n_out_last  = 1'b1;
                n_pend      = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_p       <= '0;
            r_q       <= '0;
            r_np      <= '0;
            r_chk     <= '0;
            r_ph      <= 1'b0;
            r_pend    <= 1'b0;
            r_out_stb <= 1'b0;
            r_amin    <= ASPECT_MIN_RST;
            r_amax    <= ASPECT_MAX_RST;
            r_gmin    <= GAP_MIN_RST;
            r_gmax    <= GAP_MAX_RST;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_p       <= n_p;
            r_q       <= n_q;
            r_np      <= n_np;
            r_chk     <= n_chk;
            r_ph      <= n_ph;
            r_pend    <= n_pend;
            r_out_stb <= n_out_stb;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ASPECT_MIN: r_amin <= i_cfg_data;
                    REG_ASPECT_MAX: r_amax <= i_cfg_data;
                    REG_GAP_MIN:    r_gmin <= i_cfg_data;
                    REG_GAP_MAX:    r_gmax <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_d         <= n_d;
        r_prod      <= n_prod;
        r_lhs       <= n_lhs;
        r_pd_left   <= n_pd_left;
        r_pd_top    <= n_pd_top;
        r_pd_span   <= n_pd_span;
        r_pd_hgt    <= n_pd_hgt;
        r_out_valid <= n_out_valid;
        r_out_left  <= n_out_left;
        r_out_top   <= n_out_top;
        r_out_span  <= n_out_span;
        r_out_hgt   <= n_out_hgt;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_out_stb;
    assign o_pair_valid  = r_out_valid;
    assign o_pair_left   = r_out_left;
    assign o_pair_top    = r_out_top;
    assign o_pair_span   = r_out_span;
    assign o_pair_height = r_out_hgt;
    assign o_table_full  = r_out_full;
    assign o_last        = r_out_last;

endmodule

FILE: rtl/core/lbpm_checker.sv
// Port-level checker for the light bar pair matcher, with its bind.
`include "light_bar_pair_matcher_macros.svh"

module lbpm_checker
    import lbpm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic [1:0] i_operation,
    input logic       o_strobe,
    input logic       o_pair_valid,
    input logic       o_table_full,
    input logic       o_last
);

    // table requests answer in the next cycle with a single final result
    `LBPM_ASSERT_NEXT(a_quick_reply, i_start && !o_busy && i_operation != OP_RUN, o_strobe && o_last)
    // a run holds the request side off while it scans
    `LBPM_ASSERT_NEXT(a_run_busy, i_start && !o_busy && i_operation == OP_RUN, o_busy)
    // matched pairs never report a dropped load
    `LBPM_ASSERT_NOW(a_pair_not_full, o_strobe && o_pair_valid, !o_table_full)
    // a result without a pair is always the final one of its request
    `LBPM_ASSERT_NOW(a_empty_is_last, o_strobe && !o_pair_valid, o_last)

endmodule

bind light_bar_pair_matcher lbpm_checker u_lbpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_operation  (i_operation),
    .o_strobe     (o_strobe),
    .o_pair_valid (o_pair_valid),
    .o_table_full (o_table_full),
    .o_last       (o_last)
);
